// File: design/cbf_pkg.sv
// shared constants and types for the coalescing bounded fifo
// no dependencies; imported by every module of the block except cbf_ram
package cbf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 32;

    // keys arrive on 32 bits and are kept on their low KEY_BITS bits
    localparam int KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PAY_W   = 32;
    localparam int RAM_W   = PAY_W + 1 + KEY_W;
    localparam int OCC_W   = 5;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_POPPED   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic             fin;
    } tag_wr_t;

    typedef struct packed {
        logic             hit;
        logic             fin;
        logic [IDX_W-1:0] idx;
    } match_t;

endpackage

// File: design/cbf_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cbf_tag_match.sv
// key and final-flag tags of every slot, compared in parallel on push
// depends on cbf_pkg
module cbf_tag_match
    import cbf_pkg::*;
(
    input  logic             aclk,
    input  tag_wr_t          tag_wr,
    input  logic [KEY_W-1:0] lookup_key,
    input  logic [IDX_W-1:0] head,
    input  logic [CNT_W-1:0] count,
    output match_t           match
);

    logic [KEY_W-1:0] tag_key_reg [QUEUE_DEPTH];
    logic             tag_fin_reg [QUEUE_DEPTH];
    logic [IDX_W:0]   slot_off    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] slot_hit;

    always_ff @(posedge aclk) begin
        if (tag_wr.en) begin
            tag_key_reg[tag_wr.idx] <= tag_wr.key;
            tag_fin_reg[tag_wr.idx] <= tag_wr.fin;
        end
    end

    // a slot counts only when its distance from the head is below the fill count
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((IDX_W + 1)'(i) >= {1'b0, head}) begin
                slot_off[i] = (IDX_W + 1)'(i) - {1'b0, head};
            end else begin
                slot_off[i] = (IDX_W + 1)'(i + QUEUE_DEPTH) - {1'b0, head};
            end
            slot_hit[i] = (slot_off[i] < (IDX_W + 1)'(count))
                          && (tag_key_reg[i] == lookup_key);
        end
    end

    // queued keys are unique, so at most one slot hits
    always_comb begin
        match.hit = |slot_hit;
        match.fin = 1'b0;
        match.idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_hit[i]) begin
                match.fin = match.fin | tag_fin_reg[i];
                match.idx = match.idx | IDX_W'(i);
            end
        end
    end

endmodule

// File: design/coalescing_bounded_fifo_unit.sv
// top level of the coalescing bounded fifo: handshakes, sequencer, head and count
// depends on cbf_pkg, cbf_tag_match and cbf_ram
//
// Each word on the s_ side is a push, pop or clear. A word is captured in one
// cycle and executed in the next: the push key is compared against the tags of
// all queued slots at once, the slot ram is written on append or replace, or
// read at the head on pop. In the done state that follows, the result word is loaded
// into the m_ side output register once it is free, while the next input word can
// already be taken, so the block takes a new word before the last result has left.
// Each word passes the execute state, for the tag compare and state update, and the
// done state, for the registered read of the slot ram. A stalled output register
// holds off new input only once its result is waiting and the next one is ready. Slots
// are tracked by head and fill count, so no clearing pass is needed after reset.
module coalescing_bounded_fifo_unit
    import cbf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_key [31:0], entry_final [32], entry_payload [64:33], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode [1:0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_valid [0], out_key [32:1], out_final [33], out_payload [65:34],
    // occupancy [70:66], queue_empty [71], notify [72], zero fill above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status [2:0]
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic                   fin_reg;
    logic [PAY_W-1:0]       pay_reg;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [2:0]             res_status_reg, res_status_next;
    logic                   res_notify_reg, res_notify_next;
    logic                   res_pop_reg, res_pop_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;

    logic             in_take;
    logic             out_free;
    logic             out_load;
    tag_wr_t          tag_wr;
    match_t           match;
    logic             ram_re;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_idx;
    logic             is_full;
    logic [31:0]      pop_key;
    logic             pop_fin;
    logic [PAY_W-1:0] pop_pay;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = aresetn
                      && ((state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free));
    assign in_take  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
    assign tail_idx = (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (IDX_W + 1)'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign ram_wdata = {pay_reg, fin_reg, key_reg};

    cbf_tag_match u_tag (
        .aclk       (aclk),
        .tag_wr     (tag_wr),
        .lookup_key (key_reg),
        .head       (head_reg),
        .count      (count_reg),
        .match      (match)
    );

    cbf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (tag_wr.en),
        .waddr (tag_wr.idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // execute step: decide the outcome and update tags, ram, head and count
    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_notify_next = res_notify_reg;
        res_pop_next    = res_pop_reg;
        tag_wr.en       = 1'b0;
        tag_wr.idx      = tail_idx;
        tag_wr.key      = key_reg;
        tag_wr.fin      = fin_reg;
        ram_re          = 1'b0;
        if (state_reg == S_EXEC) begin
            res_notify_next = 1'b0;
            res_pop_next    = 1'b0;
            case (op_reg)
                OP_PUSH: begin
                    if (match.hit) begin
                        if (match.fin) begin
                            res_status_next = ST_IGNORED;
                        end else begin
                            // replace in place, queue position kept
                            tag_wr.en       = 1'b1;
                            tag_wr.idx      = match.idx;
                            res_status_next = ST_REPLACED;
                            res_notify_next = 1'b1;
                        end
                    end else if (is_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        tag_wr.en       = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_APPENDED;
                        res_notify_next = 1'b1;
                    end
                end
                OP_POP: begin
                    if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                    end else begin
                        ram_re          = 1'b1;
                        res_pop_next    = 1'b1;
                        res_status_next = ST_POPPED;
                        count_next      = count_reg - 1'b1;
                        head_next       = (head_reg == IDX_W'(QUEUE_DEPTH - 1))
                                          ? '0 : head_reg + 1'b1;
                    end
                end
                default: begin
                    // clear, and the unused opcode decodes as clear too
                    head_next       = '0;
                    count_next      = '0;
                    res_status_next = ST_CLEARED;
                end
            endcase
        end
    end

    // result word assembly; the ram read data is valid in the done cycle
    assign pop_key = res_pop_reg ? 32'(ram_rdata[KEY_W-1:0]) : '0;
    assign pop_fin = res_pop_reg ? ram_rdata[KEY_W] : 1'b0;
    assign pop_pay = res_pop_reg ? ram_rdata[RAM_W-1 -: PAY_W] : '0;

    always_comb begin
        m_tdata_next = {7'b0, res_notify_reg, (count_reg == '0), OCC_W'(count_reg),
                        pop_pay, pop_fin, pop_key, res_pop_reg};
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = in_take ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            res_status_reg <= ST_APPENDED;
            res_notify_reg <= 1'b0;
            res_pop_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
            res_status_reg <= res_status_next;
            res_notify_reg <= res_notify_next;
            res_pop_reg    <= res_pop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            op_reg  <= s_tuser[1:0];
            key_reg <= s_tdata[KEY_W-1:0];
            fin_reg <= s_tdata[32];
            pay_reg <= s_tdata[64:33];
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: design/cbf_checker.sv
// port level checks for coalescing_bounded_fifo_unit, bound to the top level
// depends on cbf_pkg
module cbf_checker
    import cbf_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no input is taken in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in the execute cycle");

    // the entry fields are presented exactly on a successful pop
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tuser == ST_POPPED)))
        else $error("out_valid does not match popped status");

    // notify only on append or replace
    a_notify: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[72] == ((m_tuser == ST_APPENDED) || (m_tuser == ST_REPLACED))))
        else $error("notify does not match status");

    // after a clear or an empty pop the queue reports empty
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == ST_CLEARED) || (m_tuser == ST_EMPTY))
        |-> m_tdata[71] && (m_tdata[70:66] == '0))
        else $error("queue not empty after clear or empty pop");

endmodule

bind coalescing_bounded_fifo_unit cbf_checker u_cbf_checker (.*);
